[rtl/core/rot2eul_pkg.sv]
// Shared types, widths and constants for the rotation matrix to Euler angle block.
// Used by rotation_to_euler_angles_top; has no dependencies of its own.
package rot2eul_pkg;

  localparam int IN_W     = 18;
  localparam int ANG_W    = 20;
  localparam int TH_W     = 17;
  localparam int SQ_W     = 36;
  localparam int ROOT_W   = 18;
  localparam int XY_W     = 41;
  localparam int Z_W      = 35;
  localparam int PRE_SH   = 20;
  localparam int ANG_FRAC = 30;
  localparam int ATAN_LEN = 30;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int LANES    = 3;

  localparam logic CFG_REG_DIAG = 1'b0;
  localparam logic CFG_REG_MAG  = 1'b1;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30       = 35'sd1686629713;
  localparam logic signed [Z_W-1:0] THREE_HALF_PI_Q30 = 35'sd5059889139;

  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
  } mat_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   sing;
    logic                   guard;
    logic                   zero;
  } lane_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 35'sd843314857;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043837;
      3:  v = 35'sd133525159;
      4:  v = 35'sd67021687;
      5:  v = 35'sd33543516;
      6:  v = 35'sd16775851;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194283;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048576;
      11: v = 35'sd524288;
      12: v = 35'sd262144;
      13: v = 35'sd131072;
      14: v = 35'sd65536;
      15: v = 35'sd32768;
      16: v = 35'sd16384;
      17: v = 35'sd8192;
      18: v = 35'sd4096;
      19: v = 35'sd2048;
      20: v = 35'sd1024;
      21: v = 35'sd512;
      22: v = 35'sd256;
      23: v = 35'sd128;
      24: v = 35'sd64;
      25: v = 35'sd32;
      26: v = 35'sd16;
      27: v = 35'sd8;
      28: v = 35'sd4;
      29: v = 35'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Builds the CORDIC start vector, scaled up by 2^20.
  function automatic lane_t make_lane(input logic signed [IN_W:0] xv,
                                      input logic signed [IN_W:0] yv,
                                      input logic sing, input logic guard);
    lane_t l;
    logic signed [XY_W-1:0] xe;
    logic signed [XY_W-1:0] ye;
    xe = XY_W'(xv);
    ye = XY_W'(yv);
    l.x     = xe <<< PRE_SH;
    l.y     = ye <<< PRE_SH;
    l.z     = '0;
    l.sing  = sing;
    l.guard = guard;
    l.zero  = (xv == '0) && (yv == '0);
    return l;
  endfunction

endpackage

[rtl/core/rotation_to_euler_angles_top.sv]
// Top level of the rotation matrix to roll, pitch and yaw converter.
// Depends on rot2eul_pkg for types, widths and the arctangent table.
//
// Use: an input beat on in_t* carries six entries of a rotation matrix in
// signed Q1.16. One output beat on out_t* follows with roll, pitch and yaw
// in signed Q3.16 radians, and out_tuser holds one singular flag per angle.
// Two thresholds are written through the cfg_ APB port; the user writes them
// only while the block is idle, which the block does not enforce. The
// pipeline registers the squares, their sum, a square root giving one result
// bit per stage, the CORDIC start vectors, the CORDIC stages of the three
// lanes side by side, and the rounding into the output register. Throughput
// is one beat per cycle unless stalled; every stage holds its own valid bit.
// When the receiver stalls, full stages hold their beats and empty stages
// keep filling, so in_tready falls only once every stage is occupied.
// Reset clears all valid bits and sets both thresholds to one.
module rotation_to_euler_angles_top #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // rot_00, rot_10, rot_11, rot_20, rot_21, rot_22 (18 bits each), zero fill.
  input  logic [111:0]                        in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // roll_angle, pitch_angle, yaw_angle (20 bits each), zero fill.
  output logic [63:0]                         out_tdata,
  // roll_singular, pitch_singular, yaw_singular.
  output logic [2:0]                          out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rot2eul_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [rot2eul_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [rot2eul_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IN_W   = rot2eul_pkg::IN_W;
  localparam int ANG_W  = rot2eul_pkg::ANG_W;
  localparam int TH_W   = rot2eul_pkg::TH_W;
  localparam int SQ_W   = rot2eul_pkg::SQ_W;
  localparam int ROOT_W = rot2eul_pkg::ROOT_W;
  localparam int Z_W    = rot2eul_pkg::Z_W;
  localparam int LANES  = rot2eul_pkg::LANES;
  localparam int CS     = CORDIC_STAGES;
  localparam int SH     = rot2eul_pkg::ANG_FRAC - FRAC_BITS;

  localparam int ST_SQ0  = 2;
  localparam int ST_INIT = ST_SQ0 + ROOT_W;
  localparam int ST_OUT  = ST_INIT + CS + 1;
  localparam int NST     = ST_OUT + 1;

  localparam logic signed [Z_W-1:0] RND = (Z_W'(1) <<< SH) >>> 1;
  localparam logic signed [Z_W-1:0] FB_H_FULL = (rot2eul_pkg::HALF_PI_Q30 + RND) >>> SH;
  localparam logic signed [Z_W-1:0] FB_T_FULL =
    (rot2eul_pkg::THREE_HALF_PI_Q30 + RND) >>> SH;
  localparam logic [ANG_W-1:0] FB_HALF  = FB_H_FULL[ANG_W-1:0];
  localparam logic [ANG_W-1:0] FB_THREE = FB_T_FULL[ANG_W-1:0];

  logic [TH_W-1:0] diag_th_r;
  logic [TH_W-1:0] mag_th_r;
  logic            cfg_wr;

  logic [NST-1:0] valid_r;
  logic [NST-1:0] en;

  rot2eul_pkg::mat_t mat_in;
  rot2eul_pkg::mat_t mat0_r;
  rot2eul_pkg::mat_t mat1_r;
  rot2eul_pkg::mat_t mat_sq_r [ROOT_W];
  logic [SQ_W-1:0]   sq21_r;
  logic [SQ_W-1:0]   sq22_r;
  logic [SQ_W-1:0]   sum_r;
  logic [SQ_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  rot2eul_pkg::lane_t lane_r [CS+1][LANES];

  logic [ANG_W-1:0] ang_r  [LANES];
  logic [LANES-1:0] sing_r;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_th_r <= TH_W'(1);
      mag_th_r  <= TH_W'(1);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == rot2eul_pkg::CFG_REG_MAG) begin
        mag_th_r <= cfg_pwdata[TH_W-1:0];
      end else begin
        diag_th_r <= cfg_pwdata[TH_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == rot2eul_pkg::CFG_REG_MAG) begin
      cfg_prdata = rot2eul_pkg::CFG_DW'(mag_th_r);
    end else begin
      cfg_prdata = rot2eul_pkg::CFG_DW'(diag_th_r);
    end
  end

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    en[NST-1] = !valid_r[NST-1] || out_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign mat_in.r00 = in_tdata[17:0];
  assign mat_in.r10 = in_tdata[35:18];
  assign mat_in.r11 = in_tdata[53:36];
  assign mat_in.r20 = in_tdata[71:54];
  assign mat_in.r21 = in_tdata[89:72];
  assign mat_in.r22 = in_tdata[107:90];

  // Squares, then their sum.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mat0_r <= mat_in;
      sq21_r <= SQ_W'(mat_in.r21 * mat_in.r21);
      sq22_r <= SQ_W'(mat_in.r22 * mat_in.r22);
    end
    if (en[1]) begin
      mat1_r <= mat0_r;
      sum_r  <= sq21_r + sq22_r;
    end
  end

  // Integer square root, one result bit per stage from the top.
  for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
    localparam int J = ROOT_W - 1 - s;
    logic [SQ_W-1:0]   rem_prev;
    logic [ROOT_W-1:0] root_prev;
    rot2eul_pkg::mat_t mat_prev;
    logic [SQ_W:0]     trial;
    if (s == 0) begin : g_first
      assign rem_prev  = sum_r;
      assign root_prev = '0;
      assign mat_prev  = mat1_r;
    end else begin : g_next
      assign rem_prev  = rem_r[s-1];
      assign root_prev = root_r[s-1];
      assign mat_prev  = mat_sq_r[s-1];
    end
    assign trial = ((SQ_W+1)'(root_prev) << (J + 1)) | ((SQ_W+1)'(1) << (2 * J));
    always_ff @(posedge clk) begin
      if (en[ST_SQ0+s]) begin
        mat_sq_r[s] <= mat_prev;
        if ({1'b0, rem_prev} >= trial) begin
          rem_r[s]  <= rem_prev - trial[SQ_W-1:0];
          root_r[s] <= root_prev | (ROOT_W'(1) << J);
        end else begin
          rem_r[s]  <= rem_prev;
          root_r[s] <= root_prev;
        end
      end
    end
  end

  // Singular tests and CORDIC start vectors.
  rot2eul_pkg::mat_t  mat_last;
  logic [ROOT_W-1:0]  sp;
  logic signed [IN_W:0] dth_s;
  logic signed [IN_W:0] neg_r20;

  assign mat_last = mat_sq_r[ROOT_W-1];
  assign sp       = root_r[ROOT_W-1];
  assign dth_s    = $signed({2'b00, diag_th_r});
  assign neg_r20  = -(IN_W+1)'(mat_last.r20);

  always_ff @(posedge clk) begin
    if (en[ST_INIT]) begin
      lane_r[0][rot2eul_pkg::LANE_ROLL] <= rot2eul_pkg::make_lane(
        (IN_W+1)'(mat_last.r22), (IN_W+1)'(mat_last.r21),
        (IN_W+1)'(mat_last.r22) < dth_s, mat_last.r11 > 0);
      lane_r[0][rot2eul_pkg::LANE_PITCH] <= rot2eul_pkg::make_lane(
        $signed({1'b0, sp}), neg_r20,
        {1'b0, sp} < (ROOT_W+1)'(mag_th_r), mat_last.r20 < 0);
      lane_r[0][rot2eul_pkg::LANE_YAW] <= rot2eul_pkg::make_lane(
        (IN_W+1)'(mat_last.r00), (IN_W+1)'(mat_last.r10),
        (IN_W+1)'(mat_last.r00) < dth_s, mat_last.r10 > 0);
    end
  end

  // CORDIC vectoring stages, three lanes in parallel.
  for (genvar c = 0; c < CS; c++) begin : g_cordic
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      rot2eul_pkg::lane_t cur;
      rot2eul_pkg::lane_t nxt;
      assign cur = lane_r[c][l];
      always_comb begin
        nxt = cur;
        if (cur.y > 0) begin
          nxt.x = cur.x + (cur.y >>> c);
          nxt.y = cur.y - (cur.x >>> c);
          nxt.z = cur.z + rot2eul_pkg::atan_q30(c);
        end else begin
          nxt.x = cur.x - (cur.y >>> c);
          nxt.y = cur.y + (cur.x >>> c);
          nxt.z = cur.z - rot2eul_pkg::atan_q30(c);
        end
      end
      always_ff @(posedge clk) begin
        if (en[ST_INIT+1+c]) begin
          lane_r[c+1][l] <= nxt;
        end
      end
    end
  end

  // Rounding to the output format and fallback selection.
  for (genvar l = 0; l < LANES; l++) begin : g_out
    rot2eul_pkg::lane_t   fin;
    logic signed [Z_W-1:0] zsel;
    logic signed [Z_W-1:0] zrnd;
    assign fin  = lane_r[CS][l];
    assign zsel = fin.zero ? '0 : fin.z;
    assign zrnd = (zsel + RND) >>> SH;
    always_ff @(posedge clk) begin
      if (en[ST_OUT]) begin
        sing_r[l] <= fin.sing;
        if (fin.sing) begin
          ang_r[l] <= fin.guard ? FB_HALF : FB_THREE;
        end else begin
          ang_r[l] <= zrnd[ANG_W-1:0];
        end
      end
    end
  end

  assign out_tvalid = valid_r[NST-1];
  assign out_tdata  = {4'b0000, ang_r[rot2eul_pkg::LANE_YAW],
                       ang_r[rot2eul_pkg::LANE_PITCH], ang_r[rot2eul_pkg::LANE_ROLL]};
  assign out_tuser  = sing_r;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output stage is empty");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat present right after reset");

  a_roll_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[19:0] == FB_HALF || out_tdata[19:0] == FB_THREE)
    else $error("singular roll without a fallback angle");

  a_yaw_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata[59:40] == FB_HALF || out_tdata[59:40] == FB_THREE)
    else $error("singular yaw without a fallback angle");
`endif

endmodule

[tb/rot2eul_checker.sv]
// Checker for the rotation matrix to Euler angle block: watches both streams,
// predicts roll, pitch and yaw with a CORDIC model of its own and compares.
// Depends on rot2eul_pkg only for widths.
module rot2eul_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [111:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic [16:0] diag_th,
  input  logic [16:0] mag_th,
  output int          fail_count,
  output int          pending,
  output int          seen
);

  localparam int PRED_DEPTH = 256;

  typedef struct packed {
    logic [rot2eul_pkg::ANG_W-1:0] roll;
    logic [rot2eul_pkg::ANG_W-1:0] pitch;
    logic [rot2eul_pkg::ANG_W-1:0] yaw;
    logic [2:0]                    flags;
  } angles_t;

  angles_t pred_mem [PRED_DEPTH];
  int      wr_idx = 0;
  int      rd_idx = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, b;
    res = 0;
    b = longint'(1) <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149,
                        1048576, 524288, 262144, 131072, 65536, 32768};
    return tbl[i];
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 1048576;
    y = y * 1048576;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_entry(i);
      end else begin
        x = x - ys; y = y + xs; z = z - atan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic logic [rot2eul_pkg::ANG_W-1:0] round_q16(longint q30);
    longint v;
    v = floor_shift(q30 + (longint'(1) <<< 13), 14);
    return v[rot2eul_pkg::ANG_W-1:0];
  endfunction

  function automatic logic [rot2eul_pkg::ANG_W-1:0] fallback_angle(logic pos);
    return round_q16(pos ? 64'sd1686629713 : 64'sd5059889139);
  endfunction

  function automatic angles_t predict_angles(logic [111:0] d);
    angles_t a;
    longint r00, r10, r11, r20, r21, r22, dth, mth, sp;
    r00 = longint'($signed(d[17:0]));
    r10 = longint'($signed(d[35:18]));
    r11 = longint'($signed(d[53:36]));
    r20 = longint'($signed(d[71:54]));
    r21 = longint'($signed(d[89:72]));
    r22 = longint'($signed(d[107:90]));
    dth = longint'(diag_th);
    mth = longint'(mag_th);
    if (r22 < dth) begin
      a.roll = fallback_angle(r11 > 0); a.flags[0] = 1'b1;
    end else begin
      a.roll = round_q16(vector_angle(r22, r21)); a.flags[0] = 1'b0;
    end
    sp = int_sqrt(r21 * r21 + r22 * r22);
    if (sp < mth) begin
      a.pitch = fallback_angle(-r20 > 0); a.flags[1] = 1'b1;
    end else begin
      a.pitch = round_q16(vector_angle(sp, -r20)); a.flags[1] = 1'b0;
    end
    if (r00 < dth) begin
      a.yaw = fallback_angle(r10 > 0); a.flags[2] = 1'b1;
    end else begin
      a.yaw = round_q16(vector_angle(r00, r10)); a.flags[2] = 1'b0;
    end
    return a;
  endfunction

  assign pending = wr_idx - rd_idx;

  always @(posedge clk) begin
    angles_t e;
    if (!rst_n) begin
      fail_count <= 0;
      seen <= 0;
      wr_idx <= 0;
      rd_idx <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pred_mem[wr_idx % PRED_DEPTH] <= predict_angles(in_tdata);
        wr_idx <= wr_idx + 1;
      end
      if (out_tvalid && out_tready) begin
        seen <= seen + 1;
        if (wr_idx == rd_idx) begin
          $error("output beat with no prediction waiting");
          fail_count <= fail_count + 1;
        end else begin
          e = pred_mem[rd_idx % PRED_DEPTH];
          rd_idx <= rd_idx + 1;
          if (out_tdata[19:0] !== e.roll || out_tdata[39:20] !== e.pitch ||
              out_tdata[59:40] !== e.yaw || out_tdata[63:60] !== 4'd0 ||
              out_tuser !== e.flags) begin
            if (out_tdata[19:0] !== e.roll)
              $error("roll_angle expected %0d got %0d", e.roll, out_tdata[19:0]);
            if (out_tdata[39:20] !== e.pitch)
              $error("pitch_angle expected %0d got %0d", e.pitch, out_tdata[39:20]);
            if (out_tdata[59:40] !== e.yaw)
              $error("yaw_angle expected %0d got %0d", e.yaw, out_tdata[59:40]);
            if (out_tdata[63:60] !== 4'd0)
              $error("zero fill expected 0 got %0h", out_tdata[63:60]);
            if (out_tuser !== e.flags)
              $error("singular flags expected %b got %b", e.flags, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb.sv]
// Testbench top: drives matrix beats and threshold writes into the block and
// gives the verdict. Depends on rot2eul_pkg, the block and rot2eul_checker.
module tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [rot2eul_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [rot2eul_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [rot2eul_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;
  logic [16:0] diag_th = 17'd1, mag_th = 17'd1;
  int fail_count, pending, seen;
  int send_idle = 0, recv_idle = 0;
  int cycles = 0;
  int sent = 0;

  always #4 clk = ~clk;

  rotation_to_euler_angles_top dut (.*);

  rot2eul_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  task automatic write_reg(logic [rot2eul_pkg::CFG_AW-1:0] addr, logic [16:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= addr; cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == 3'(4 * rot2eul_pkg::CFG_REG_DIAG)) diag_th <= val; else mag_th <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_matrix(logic [17:0] r00, r10, r11, r20, r21, r22);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, r22, r21, r20, r11, r10, r00};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [17:0] pick_entry();
    case ($urandom_range(9))
      0: return 18'(65536);
      1: return 18'(-65536);
      2: return 18'($urandom_range(3));
      3: return 18'($urandom);
      default: return 18'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  task automatic send_random(int n);
    logic [17:0] c, s;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_matrix(pick_entry(), pick_entry(), pick_entry(), pick_entry(),
                    pick_entry(), pick_entry());
      end else begin
        c = pick_entry(); s = pick_entry();
        send_matrix(c, s, pick_entry(), pick_entry(), s, c);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_matrix(18'(65536), 18'd0, 18'(65536), 18'd0, 18'd0, 18'(65536));
    send_matrix(18'(-65536), 18'd0, 18'(-65536), 18'd0, 18'd0, 18'(-65536));
    send_matrix(18'd0, 18'(65536), 18'd0, 18'(65536), 18'(65536), 18'd0);
    send_matrix(18'd0, 18'(-65536), 18'd1, 18'(-65536), 18'(-65536), 18'd0);
    send_matrix(18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0);
    send_matrix(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000, 18'h20000, 18'h1ffff);
    send_matrix(18'h20000, 18'h1ffff, 18'h20000, 18'h1ffff, 18'h1ffff, 18'h20000);
    send_matrix(18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1);
    send_matrix(18'(46341), 18'(46341), 18'(-5), 18'(-46341), 18'(46341), 18'(46341));
    in_tvalid <= 1'b0;
    drain();
    write_reg(3'(4 * rot2eul_pkg::CFG_REG_DIAG), 17'd0);
    write_reg(3'(4 * rot2eul_pkg::CFG_REG_MAG), 17'd0);
    send_matrix(18'd0, 18'd0, 18'd0, 18'd5, 18'd0, 18'd0);
    send_matrix(18'd0, 18'd7, 18'd0, 18'd0, 18'd3, 18'd0);
    in_tvalid <= 1'b0;
    drain();
    send_idle = 24; recv_idle = 47;
    send_random(350);
    drain();
    write_reg(3'(4 * rot2eul_pkg::CFG_REG_DIAG), 17'd65536);
    write_reg(3'(4 * rot2eul_pkg::CFG_REG_MAG), 17'd65536);
    send_idle = 47; recv_idle = 24;
    send_random(350);
    drain();
    write_reg(3'(4 * rot2eul_pkg::CFG_REG_DIAG), 17'($urandom_range(40000)));
    write_reg(3'(4 * rot2eul_pkg::CFG_REG_MAG), 17'($urandom_range(40000)));
    send_idle = 0; recv_idle = 0;
    send_random(340);
    drain();
    $display("Sent %0d matrices, checked %0d angle beats over four threshold settings.",
             sent, seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/rot2eul_pkg.sv
rtl/core/rotation_to_euler_angles_top.sv
tb/rot2eul_checker.sv
tb/tb.sv
